### hw/rtl/sio_rf_pkg.sv
// ============================================================================
// sio_rf_pkg
// Shared types and constants of the index/data configuration register file.
// ============================================================================
package sio_rf_pkg;

    // Sizing of the register file.
    localparam int GLOBAL_REG_COUNT    = 48;
    localparam int DEVICE_COUNT        = 16;
    localparam int SERIAL_COUNT        = 2;
    localparam int FIRST_SERIAL_DEVICE = 4;

    // Well-known register numbers.
    localparam logic [7:0]  REG_DEVICE_NUMBER = 8'h07;
    localparam logic [7:0]  REG_BASE_LOW      = 8'h26;
    localparam logic [7:0]  REG_BASE_HIGH     = 8'h27;
    localparam logic [15:0] BASE_ADDRESS      = 16'h002E;
    localparam logic [7:0]  DEV_ACTIVATE      = 8'h30;
    localparam logic [7:0]  DEV_INTERRUPT     = 8'h70;

    // Reset values of the mode keys.
    localparam logic [7:0] ENTER_KEY_RESET = 8'h55;
    localparam logic [7:0] EXIT_KEY_RESET  = 8'hAA;

    // Configuration register indexes.
    localparam logic CFG_ENTER_KEY = 1'b0;
    localparam logic CFG_EXIT_KEY  = 1'b1;

    // Bus access codes.
    localparam logic       OP_READ    = 1'b0;
    localparam logic       OP_WRITE   = 1'b1;
    localparam logic [1:0] PORT_INDEX = 2'd0;
    localparam logic [1:0] PORT_DATA  = 2'd1;

    typedef struct packed {
        logic       operation;
        logic [1:0] port_offset;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       handled;
        logic       in_config_mode;
        logic [1:0] activate_mask;
        logic [7:0] serial0_irq;
        logic [7:0] serial1_irq;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

### hw/rtl/sio_rf_ctrl.sv
// ============================================================================
// sio_rf_ctrl
// Sequencer: clearing sweep after reset, then load, execute and hand over
// one access at a time.
// ============================================================================
module sio_rf_ctrl
    import sio_rf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // The input and output sides are never open in the same cycle.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    // An accepted beat always moves straight to its execute step.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (cmd.exec && !in_ready && !out_valid))
        else $error("accepted beat not executed");

    // Execution always leads straight to a presented result.
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid)
        else $error("executed beat produced no result");

    // No beat is taken while the clearing sweep runs.
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (!in_ready && !out_valid))
        else $error("handshake open during clearing sweep");

endmodule

### hw/rtl/sio_rf_dp.sv
// ============================================================================
// sio_rf_dp
// Datapath: key, index and mode registers, global and device register
// memories, serial device shadows and the result registers.
// ============================================================================
module sio_rf_dp
    import sio_rf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  in_item_t   in_item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  out_item
);

    localparam int GLOB_W   = (GLOBAL_REG_COUNT > 1) ? $clog2(GLOBAL_REG_COUNT) : 1;
    localparam int DEV_W    = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
    localparam int DADDR_W  = DEV_W + 8;
    localparam int DEV_DEPTH = (2 ** DEV_W) * 256;

    // Serial devices that have a register bank behind them.
    localparam logic [1:0] SERIAL_PRESENT = {
        (SERIAL_COUNT > 1) && (FIRST_SERIAL_DEVICE + 1 < DEVICE_COUNT),
        (FIRST_SERIAL_DEVICE < DEVICE_COUNT)
    };

    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_GLOBAL = 2'd1,
        RD_DEVICE = 2'd2
    } rd_src_t;

    function automatic logic [7:0] glob_reset_value(input logic [7:0] a);
        logic [7:0] v;
        v = 8'h00;
        if (a == REG_BASE_LOW)
        begin
            v = BASE_ADDRESS[7:0];
        end
        else if (a == REG_BASE_HIGH)
        begin
            v = BASE_ADDRESS[15:8];
        end
        return v;
    endfunction

    // Control state.
    logic [7:0]         enter_key_reg;
    logic [7:0]         exit_key_reg;
    logic [7:0]         idx_reg;
    logic               mode_reg;
    logic [7:0]         dev_num_reg;
    logic [1:0]         act_nz_reg;
    logic [7:0]         sirq_reg [2];
    logic [1:0]         active_reg;
    logic [GLOBAL_REG_COUNT-1:0] glob_vld_reg;
    logic [DADDR_W-1:0] clr_cnt_reg;

    // Payload.
    in_item_t           item_reg;
    logic [7:0]         glob_mem [GLOBAL_REG_COUNT];
    logic [7:0]         dev_mem  [DEV_DEPTH];
    logic [7:0]         glob_rd_reg;
    logic               glob_rd_vld_reg;
    logic [7:0]         glob_rd_rst_reg;
    logic [7:0]         dev_rd_reg;
    rd_src_t            rd_src_reg;
    logic               res_handled_reg;
    logic               res_mode_reg;
    logic [1:0]         res_mask_reg;
    logic [7:0]         res_irq_reg [2];

    // Decode of the held access.
    logic               is_idx;
    logic               is_data;
    logic               is_wr;
    logic               idx_global;
    logic               dev_ok;
    logic               key_enter;
    logic               key_exit;
    logic               idx_load;
    logic               glob_wr;
    logic               glob_rd;
    logic               dev_wr;
    logic               dev_rd;
    logic               mode_after;
    logic [1:0]         act_fire;
    logic [GLOB_W-1:0]  glob_addr;
    logic [DADDR_W-1:0] dev_addr;
    logic               dev_we;
    logic [DADDR_W-1:0] dev_waddr;
    logic [7:0]         dev_wdata;

    always_comb
    begin
        is_idx     = (item_reg.port_offset == PORT_INDEX);
        is_data    = (item_reg.port_offset == PORT_DATA);
        is_wr      = (item_reg.operation == OP_WRITE);
        idx_global = (idx_reg < 8'(GLOBAL_REG_COUNT));
        dev_ok     = (dev_num_reg < 8'(DEVICE_COUNT));

        // The enter key wins when both keys hold the same value.
        key_enter  = cmd.exec && is_idx && is_wr && (item_reg.write_data == enter_key_reg);
        key_exit   = cmd.exec && is_idx && is_wr && !key_enter
                     && (item_reg.write_data == exit_key_reg);
        idx_load   = cmd.exec && is_idx && is_wr && !key_enter && !key_exit;

        glob_wr    = cmd.exec && is_data && idx_global && is_wr;
        glob_rd    = cmd.exec && is_data && idx_global && !is_wr;
        dev_wr     = cmd.exec && is_data && !idx_global && dev_ok && is_wr;
        dev_rd     = cmd.exec && is_data && !idx_global && dev_ok && !is_wr;

        mode_after = key_enter ? 1'b1 : (key_exit ? 1'b0 : mode_reg);

        for (int i = 0; i < 2; i++)
        begin
            act_fire[i] = key_exit && SERIAL_PRESENT[i] && act_nz_reg[i] && !active_reg[i];
        end

        glob_addr  = idx_reg[GLOB_W-1:0];
        dev_addr   = {dev_num_reg[DEV_W-1:0], idx_reg};

        // One write port, shared by the clearing sweep and data-port writes.
        dev_we     = cmd.clear || dev_wr;
        dev_waddr  = cmd.clear ? clr_cnt_reg : dev_addr;
        dev_wdata  = cmd.clear ? 8'h00 : item_reg.write_data;

        status.clear_last = (clr_cnt_reg == '1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_key_reg <= ENTER_KEY_RESET;
            exit_key_reg  <= EXIT_KEY_RESET;
            idx_reg       <= '0;
            mode_reg      <= 1'b0;
            dev_num_reg   <= '0;
            act_nz_reg    <= '0;
            sirq_reg[0]   <= '0;
            sirq_reg[1]   <= '0;
            active_reg    <= '0;
            glob_vld_reg  <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ENTER_KEY)
                begin
                    enter_key_reg <= cfg_data;
                end
                else
                begin
                    exit_key_reg <= cfg_data;
                end
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (idx_load)
            begin
                idx_reg <= item_reg.write_data;
            end
            mode_reg <= mode_after;
            if (glob_wr)
            begin
                glob_vld_reg[glob_addr] <= 1'b1;
                if (idx_reg == REG_DEVICE_NUMBER)
                begin
                    dev_num_reg <= item_reg.write_data;
                end
            end
            for (int i = 0; i < 2; i++)
            begin
                // Shadows of each serial device's IRQ byte and of whether its activate byte is nonzero.
                if (dev_wr && (dev_num_reg == 8'(FIRST_SERIAL_DEVICE + i)))
                begin
                    if (idx_reg == DEV_ACTIVATE)
                    begin
                        act_nz_reg[i] <= (item_reg.write_data != 8'h00);
                    end
                    if (idx_reg == DEV_INTERRUPT)
                    begin
                        sirq_reg[i] <= item_reg.write_data;
                    end
                end
                if (act_fire[i])
                begin
                    active_reg[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (glob_wr)
        begin
            glob_mem[glob_addr] <= item_reg.write_data;
        end
        if (glob_rd)
        begin
            glob_rd_reg     <= glob_mem[glob_addr];
            glob_rd_vld_reg <= glob_vld_reg[glob_addr];
            glob_rd_rst_reg <= glob_reset_value(idx_reg);
        end
        if (dev_we)
        begin
            dev_mem[dev_waddr] <= dev_wdata;
        end
        if (dev_rd)
        begin
            dev_rd_reg <= dev_mem[dev_addr];
        end
        if (cmd.exec)
        begin
            rd_src_reg      <= glob_rd ? RD_GLOBAL : (dev_rd ? RD_DEVICE : RD_NONE);
            res_handled_reg <= is_idx || is_data;
            res_mode_reg    <= mode_after;
            res_mask_reg    <= act_fire;
            for (int i = 0; i < 2; i++)
            begin
                res_irq_reg[i] <= act_fire[i] ? sirq_reg[i] : 8'h00;
            end
        end
    end

    always_comb
    begin
        out_item = '0;
        unique case (rd_src_reg)
            RD_GLOBAL: out_item.read_data = glob_rd_vld_reg ? glob_rd_reg : glob_rd_rst_reg;
            RD_DEVICE: out_item.read_data = dev_rd_reg;
            default:   out_item.read_data = 8'h00;
        endcase
        out_item.handled        = res_handled_reg;
        out_item.in_config_mode = res_mode_reg;
        out_item.activate_mask  = res_mask_reg;
        out_item.serial0_irq    = res_irq_reg[0];
        out_item.serial1_irq    = res_irq_reg[1];
    end

endmodule

### hw/rtl/super_io_config_register_file.sv
// ============================================================================
// super_io_config_register_file
// Index/data port configuration register file with global and per-device
// register banks, mode keys and serial device activation.
// ============================================================================
// Sequence: a beat accepted in the idle state is latched, executed in the
// execute state and then presented in the output state until it is taken.
// One access at a time (load, execute, hand over): no new beat is accepted until
// the result is taken. Register memories are read or written in the execute cycle.
// Reset: asynchronous, active low. Keys return to 0x55 and 0xAA, index, mode
// and activation flags clear; a sweep then zeroes the device banks, during
// which no beat is accepted (configuration writes are still taken).
module super_io_config_register_file
    import sio_rf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    // The controller sequences each access; the datapath holds the register file state.
    dp_cmd_t    cmd;
    dp_status_t status;

    // The sequencer opens the input side only when idle, runs an execute step
    // for each beat and holds the result until the consumer takes it.
    sio_rf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath latches the beat, performs its register access in the
    // execute cycle and keeps the result fields stable while presented.
    sio_rf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule
